### design/asd_pkg.sv
package asd_pkg;

   localparam int unsigned WORD_W       = 16;
   localparam int unsigned SEGMENT_W    = 4;
   localparam int unsigned CHANNEL_W    = 6;
   localparam int unsigned POSITION_W   = 8;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [WORD_W-1:0]    START_MARKER_RESET    = 16'hF005;
   localparam logic [WORD_W-1:0]    END_MARKER_RESET      = 16'hBA11;
   localparam logic [WORD_W-1:0]    FILE_END_MARKER_RESET = 16'h4321;
   localparam logic [WORD_W-1:0]    MIN_START_GAP_RESET   = 16'd1551;
   localparam logic [WORD_W-1:0]    WORD_MAX              = 16'hFFFF;
   localparam logic [SEGMENT_W-1:0] SEGMENT_MAX           = 4'd15;
   localparam logic [CHANNEL_W-1:0] CHANNEL_MAX           = 6'd63;
   localparam logic [CHANNEL_W-1:0] CHANNEL_FIRST         = 6'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_MARKER    = 2'd0,
      CSR_END_MARKER      = 2'd1,
      CSR_FILE_END_MARKER = 2'd2,
      CSR_MIN_START_GAP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              buffer_last;
   } req_type;

   typedef struct packed {
      logic                  is_status;
      logic [WORD_W-1:0]     sample;
      logic [CHANNEL_W-1:0]  channel;
      logic [POSITION_W-1:0] sample_index;
      logic                  channel_full;
      logic                  corrupt;
      logic [SEGMENT_W-1:0]  segments_found;
      logic [CHANNEL_W-1:0]  channels_found;
      logic                  last;
   } rsp_type;

   // one queued job: an optional sample and an optional status behind it
   typedef struct packed {
      logic                  has_sample;
      logic                  has_status;
      logic [WORD_W-1:0]     sample;
      logic [CHANNEL_W-1:0]  channel;
      logic [POSITION_W-1:0] sample_index;
      logic                  channel_full;
      logic                  corrupt;
      logic [SEGMENT_W-1:0]  segments_found;
      logic [CHANNEL_W-1:0]  channels_found;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/asd_stream_if.sv
interface asd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/asd_front.sv
module asd_front #(
   parameter int unsigned CHIP_COUNT          = 5,
   parameter int unsigned CHANNEL_TOTAL       = 30,
   parameter int unsigned SAMPLES_PER_CHANNEL = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [asd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [asd_pkg::WORD_W-1:0]         csr_wdata,
   asd_stream_if.sink                         req_chan,
   input  asd_pkg::queue_status_type          queue_status,
   output logic                               push,
   output asd_pkg::work_type                  push_work
);

   localparam logic [asd_pkg::POSITION_W:0]  SPC     = (asd_pkg::POSITION_W+1)'(SAMPLES_PER_CHANNEL);
   localparam logic [asd_pkg::SEGMENT_W-1:0] CHIPS   = asd_pkg::SEGMENT_W'(CHIP_COUNT);
   localparam logic [asd_pkg::CHANNEL_W-1:0] CHANNELS = asd_pkg::CHANNEL_W'(CHANNEL_TOTAL);

   logic [asd_pkg::WORD_W-1:0]     start_marker_ff, end_marker_ff, file_end_marker_ff;
   logic [asd_pkg::WORD_W-1:0]     min_start_gap_ff;

   logic                           collecting_ff, collecting_in;
   logic                           start_seen_ff, start_seen_in;
   logic [asd_pkg::WORD_W-1:0]     since_start_ff, since_start_in;
   logic [asd_pkg::SEGMENT_W-1:0]  segment_count_ff, segment_count_in;
   logic [asd_pkg::CHANNEL_W-1:0]  channel_number_ff, channel_number_in;
   logic [asd_pkg::POSITION_W-1:0] position_ff, position_in;
   logic [asd_pkg::CHANNEL_W-1:0]  channels_done_ff, channels_done_in;

   logic                           accept;
   logic [asd_pkg::WORD_W-1:0]     start_dist;
   logic                           is_close;
   logic                           sample_fire;
   logic                           chan_full;
   logic                           start_ok;
   asd_pkg::csr_index_type         csr_sel;

   assign csr_sel = asd_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff    <= asd_pkg::START_MARKER_RESET;
         end_marker_ff      <= asd_pkg::END_MARKER_RESET;
         file_end_marker_ff <= asd_pkg::FILE_END_MARKER_RESET;
         min_start_gap_ff   <= asd_pkg::MIN_START_GAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_sel)
            asd_pkg::CSR_START_MARKER:    start_marker_ff    <= csr_wdata;
            asd_pkg::CSR_END_MARKER:      end_marker_ff      <= csr_wdata;
            asd_pkg::CSR_FILE_END_MARKER: file_end_marker_ff <= csr_wdata;
            asd_pkg::CSR_MIN_START_GAP:   min_start_gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      start_dist  = (since_start_ff == asd_pkg::WORD_MAX) ? since_start_ff
                                                          : since_start_ff + 16'd1;
      is_close    = (req_chan.data.word == end_marker_ff) ||
                    (req_chan.data.word == file_end_marker_ff);
      sample_fire = collecting_ff && !is_close;
      chan_full   = ({1'b0, position_ff} + 9'd1) == SPC;
      start_ok    = !collecting_ff && (req_chan.data.word == start_marker_ff) &&
                    (!start_seen_ff || (start_dist >= min_start_gap_ff));

      collecting_in     = collecting_ff;
      start_seen_in     = start_seen_ff;
      since_start_in    = start_dist;
      segment_count_in  = segment_count_ff;
      channel_number_in = channel_number_ff;
      position_in       = position_ff;
      channels_done_in  = channels_done_ff;

      if (collecting_ff && is_close) begin
         collecting_in = 1'b0;
      end
      if (sample_fire) begin
         if (chan_full) begin
            position_in = '0;
            if (channels_done_ff != asd_pkg::CHANNEL_MAX) begin
               channels_done_in = channels_done_ff + 6'd1;
            end
            channel_number_in = (channels_done_in != asd_pkg::CHANNEL_MAX)
                                ? channels_done_in + 6'd1 : asd_pkg::CHANNEL_MAX;
         end else begin
            position_in = position_ff + 8'd1;
         end
      end
      if (start_ok) begin
         start_seen_in  = 1'b1;
         collecting_in  = 1'b1;
         since_start_in = '0;
         position_in    = '0;
         if (segment_count_ff != asd_pkg::SEGMENT_MAX) begin
            segment_count_in = segment_count_ff + 4'd1;
         end
      end

      push_work.has_sample     = sample_fire;
      push_work.has_status     = req_chan.data.buffer_last;
      push_work.sample         = req_chan.data.word;
      push_work.channel        = channel_number_ff;
      push_work.sample_index   = position_ff;
      push_work.channel_full   = chan_full;
      push_work.corrupt        = (segment_count_in != CHIPS) || (channels_done_in != CHANNELS);
      push_work.segments_found = segment_count_in;
      push_work.channels_found = channels_done_in;
      push = accept && (sample_fire || req_chan.data.buffer_last);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.data.buffer_last)) begin
         collecting_ff     <= 1'b0;
         start_seen_ff     <= 1'b0;
         since_start_ff    <= '0;
         segment_count_ff  <= '0;
         channel_number_ff <= asd_pkg::CHANNEL_FIRST;
         position_ff       <= '0;
         channels_done_ff  <= '0;
      end else if (accept) begin
         collecting_ff     <= collecting_in;
         start_seen_ff     <= start_seen_in;
         since_start_ff    <= since_start_in;
         segment_count_ff  <= segment_count_in;
         channel_number_ff <= channel_number_in;
         position_ff       <= position_in;
         channels_done_ff  <= channels_done_in;
      end
   end

endmodule

### design/asd_queue.sv
module asd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  asd_pkg::work_type          push_work,
   input  logic                       pop,
   output asd_pkg::work_type          head,
   output asd_pkg::queue_status_type  status
);

   asd_pkg::work_type                 mem_ff [asd_pkg::QUEUE_DEPTH];
   logic [asd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [asd_pkg::QUEUE_PTR_W:0]     count_ff;

   always_comb begin
      status.full  = count_ff == (asd_pkg::QUEUE_PTR_W+1)'(asd_pkg::QUEUE_DEPTH);
      status.empty = count_ff == '0;
      head         = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### design/asd_back.sv
module asd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  asd_pkg::work_type          head,
   input  asd_pkg::queue_status_type  queue_status,
   output logic                       pop,
   asd_stream_if.source               rsp_chan
);

   logic              out_valid_ff, out_valid_in;
   asd_pkg::rsp_type  out_ff, out_in;
   logic              phase_ff, phase_in;
   logic              load;

   always_comb begin
      load         = !out_valid_ff || rsp_chan.ready;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;

      if (load) begin
         out_valid_in = !queue_status.empty;
         out_in       = '0;
         if (!queue_status.empty) begin
            if (head.has_sample && !phase_ff) begin
               out_in.sample       = head.sample;
               out_in.channel      = head.channel;
               out_in.sample_index = head.sample_index;
               out_in.channel_full = head.channel_full;
               out_in.last         = !head.has_status;
               // the status word of the same input goes out next
               phase_in = head.has_status;
               pop      = !head.has_status;
            end else begin
               out_in.is_status      = 1'b1;
               out_in.corrupt        = head.corrupt;
               out_in.segments_found = head.segments_found;
               out_in.channels_found = head.channels_found;
               out_in.last           = 1'b1;
               phase_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule

### design/adc_segment_deframer_core.sv
// adc segment deframer
// req_chan takes one readout word per cycle, while the queue is not full, with
// a buffer_last flag. inside a segment (opened by an accepted start word, closed
// by an end or end-of-file word) every word comes out on rsp_chan as a sample
// tagged with channel and index. the buffer's last word also yields a status
// word with the segment and full channel counts and a corrupt flag; state then
// clears for a new buffer. the front classifies words and updates all counters
// in the cycle a word is taken; jobs go through a four-entry queue to the back,
// which drives a registered output. an input that gives a sample and a status
// yields two output words, so sustained output is one word per cycle while the
// receiver is ready. when the receiver stalls the queue absorbs up to four jobs
// plus the output register, then req_chan.ready drops. reset is synchronous: it
// restores the marker and gap registers, empties the queue and clears the output
// valid. csr writes (csr_wr_en, csr_index, csr_wdata) are registered.
module adc_segment_deframer_core #(
   parameter int unsigned CHIP_COUNT          = 5,
   parameter int unsigned CHANNEL_TOTAL       = 30,
   parameter int unsigned SAMPLES_PER_CHANNEL = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [asd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asd_pkg::WORD_W-1:0]      csr_wdata,
   asd_stream_if.sink                      req_chan,
   asd_stream_if.source                    rsp_chan
);

   logic                       push;
   logic                       pop;
   asd_pkg::work_type          push_work;
   asd_pkg::work_type          head;
   asd_pkg::queue_status_type  queue_status;

   asd_front #(
      .CHIP_COUNT          (CHIP_COUNT),
      .CHANNEL_TOTAL       (CHANNEL_TOTAL),
      .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .push         (push),
      .push_work    (push_work)
   );

   asd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   asd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!queue_status.full || pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("job queue underflow");

   a_status_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.data.is_status &&
       !rsp_chan.data.last) |=> (rsp_chan.valid && rsp_chan.data.is_status))
      else $error("status word did not follow its sample");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("output valid after reset");
`endif

endmodule
